// File: rtl/slscp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sLiSCP-light-256 shared definitions
// Types and constants shared by the controller and the datapath of the
// permutation block, plus the step constant table and round functions of the datapath.
// ----------------------------------------------------------------------------
package slscp_pkg;

  // Number of steps in the full permutation; also the step constant count
  localparam int MAX_STEPS = 18;
  // Width of the step counter and of the configuration register
  localparam int STEP_W = 5;
  localparam int WORD_W = 32;
  localparam int NUM_WORDS = 8;

  typedef logic [WORD_W-1:0] word_t;
  // Element k holds word xk of the state
  typedef word_t [NUM_WORDS-1:0] state_t;
  typedef logic [STEP_W-1:0] step_cnt_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } ctrl_state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load;
    logic      step;
    logic      emit;
    step_cnt_t step_idx;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // Step constants packed as {round bits A, round bits B, step const A, step const B}
  function automatic logic [31:0] step_const(input step_cnt_t idx);
    logic [31:0] c;
    case (idx)
      5'd0:    c = 32'h0f47_0864;
      5'd1:    c = 32'h04b2_866b;
      5'd2:    c = 32'h43b5_e26f;
      5'd3:    c = 32'hf137_892c;
      5'd4:    c = 32'h4496_e6dd;
      5'd5:    c = 32'h73ee_ca99;
      5'd6:    c = 32'he54c_17ea;
      5'd7:    c = 32'h0bf5_8e0f;
      5'd8:    c = 32'h4707_6404;
      5'd9:    c = 32'hb282_6b43;
      5'd10:   c = 32'hb5a1_6ff1;
      5'd11:   c = 32'h3778_2c44;
      5'd12:   c = 32'h96a2_dd73;
      5'd13:   c = 32'heeb9_99e5;
      5'd14:   c = 32'h4cf2_ea0b;
      5'd15:   c = 32'hf585_0f47;
      5'd16:   c = 32'h0723_04b2;
      5'd17:   c = 32'h82d9_43b5;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Simeck round function with one round-constant bit
  function automatic word_t simeck_f(input word_t x, input logic rc_bit);
    word_t rot5;
    word_t rot1;
    rot5 = {x[WORD_W-6:0], x[WORD_W-1:WORD_W-5]};
    rot1 = {x[WORD_W-2:0], x[WORD_W-1]};
    return (rot5 & x) ^ rot1 ^ 32'hFFFF_FFFE ^ {{(WORD_W-1){1'b0}}, rc_bit};
  endfunction

  // Eight Simeck rounds on a word pair; returns {a, b}
  function automatic logic [2*WORD_W-1:0] simeck_box(input word_t a_in, input word_t b_in,
                                                     input logic [7:0] rc);
    word_t a;
    word_t b;
    a = a_in;
    b = b_in;
    for (int r = 0; r < 4; r++) begin
      b = b ^ simeck_f(a, rc[2*r]);
      a = a ^ simeck_f(b, rc[2*r+1]);
    end
    return {a, b};
  endfunction

  // One full permutation step
  function automatic state_t perm_step(input state_t w, input logic [31:0] c);
    state_t s;
    state_t r;
    s = w;
    {s[2], s[3]} = simeck_box(w[2], w[3], c[31:24]);
    {s[6], s[7]} = simeck_box(w[6], w[7], c[23:16]);
    s[0] = s[0] ^ 32'hFFFF_FFFF;
    s[1] = s[1] ^ 32'hFFFF_FF00 ^ {24'h0, c[15:8]};
    s[4] = s[4] ^ 32'hFFFF_FFFF;
    s[5] = s[5] ^ 32'hFFFF_FF00 ^ {24'h0, c[7:0]};
    r[0] = s[2];
    r[1] = s[3];
    r[2] = s[4] ^ s[6];
    r[3] = s[5] ^ s[7];
    r[4] = s[6];
    r[5] = s[7];
    r[6] = s[0] ^ s[2];
    r[7] = s[1] ^ s[3];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/slscp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sLiSCP-light-256 controller
// Holds the step count register, sequences the steps of one item and hands
// the finished state to the output register.
// ----------------------------------------------------------------------------
module slscp_ctrl (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [4:0]             cfg_wdata_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire slscp_pkg::dp_status_t  status_i,
  output slscp_pkg::ctrl_cmd_t        cmd_o
);
  import slscp_pkg::*;

  ctrl_state_e state_q, state_d;
  step_cnt_t   round_count_q;
  step_cnt_t   cnt_q, cnt_d;
  step_cnt_t   limit_q, limit_d;
  step_cnt_t   limit_sat;

  // Saturate the configured step count
  assign limit_sat = (round_count_q > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS)
                                                          : round_count_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= STEP_W'(MAX_STEPS);
    end else if (cfg_we_i) begin
      round_count_q <= cfg_wdata_i;
    end
  end

  // State, counter and limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      limit_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      limit_q <= limit_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    limit_d        = limit_q;
    in_stall_o     = 1'b1;
    cmd_o.load     = 1'b0;
    cmd_o.step     = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.step_idx = cnt_q;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          limit_d    = limit_sat;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_q != limit_q) begin
          // advance one step
          cmd_o.step = 1'b1;
          cnt_d      = cnt_q + 1'b1;
        end else if (status_i.out_free) begin
          // hand the result to the output register
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef ASSERT_OFF
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= limit_q))
    else $error("step counter passed its limit");
  a_limit_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (limit_q <= STEP_W'(MAX_STEPS)))
    else $error("step limit not saturated");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (status_i.out_free && cnt_q == limit_q))
    else $error("emit while output register busy or steps pending");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_RUN && cnt_q == '0))
    else $error("load did not start a run");
`endif

endmodule
`default_nettype wire

// File: rtl/slscp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sLiSCP-light-256 datapath
// Working state register with one permutation step per cycle, and the output
// register that holds a finished item until the receiver takes it.
// ----------------------------------------------------------------------------
module slscp_dp (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire slscp_pkg::ctrl_cmd_t   cmd_i,
  output slscp_pkg::dp_status_t       status_o,
  input  wire logic [63:0]            state_in_0_i,
  input  wire logic [63:0]            state_in_1_i,
  input  wire logic [63:0]            state_in_2_i,
  input  wire logic [63:0]            state_in_3_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [63:0]                 state_out_0_o,
  output logic [63:0]                 state_out_1_o,
  output logic [63:0]                 state_out_2_o,
  output logic [63:0]                 state_out_3_o
);
  import slscp_pkg::*;

  state_t work_q, work_d;
  state_t out_q;
  logic   out_valid_q, out_valid_d;

  // Load, step or hold the working state
  always_comb begin
    work_d = work_q;
    if (cmd_i.load) begin
      work_d = {state_in_3_i[31:0], state_in_3_i[63:32],
                state_in_2_i[31:0], state_in_2_i[63:32],
                state_in_1_i[31:0], state_in_1_i[63:32],
                state_in_0_i[31:0], state_in_0_i[63:32]};
    end else if (cmd_i.step) begin
      work_d = perm_step(work_q, step_const(cmd_i.step_idx));
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= work_q;
    end
  end

  // Output valid: set on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign state_out_0_o     = {out_q[0], out_q[1]};
  assign state_out_1_o     = {out_q[2], out_q[3]};
  assign state_out_2_o     = {out_q[4], out_q[5]};
  assign state_out_3_o     = {out_q[6], out_q[7]};

endmodule
`default_nettype wire

// File: rtl/sliscp_light256_permutation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sLiSCP-light-256 permutation
// Applies a configured number of sLiSCP-light-256 steps to a 256-bit state.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o carries the state as four big-endian
//   64-bit words; output channel out_valid_o/out_stall_i returns the permuted
//   state in the same layout. An item moves at an edge with valid high and
//   stall low.
//   cfg_we_i/cfg_wdata_i write the step count (reset 18, values above 18
//   act as 18); write it only while no item is in flight.
//   One item is worked at a time. The working register applies one full step
//   (eight Simeck rounds on each box) per cycle; after the last step the
//   controller emits the state into the output register and returns to idle
//   before it takes the next item.
//   The output register lets the next item be accepted and worked while a
//   result waits; if the receiver keeps stalling, the finished item holds in
//   the working register and input stays stalled until the output frees.
//   Reset clears the controller and output valid and sets the count to 18.
// ----------------------------------------------------------------------------
module sliscp_light256_permutation (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [63:0] state_in_0_i,
  input  wire logic [63:0] state_in_1_i,
  input  wire logic [63:0] state_in_2_i,
  input  wire logic [63:0] state_in_3_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      state_out_0_o,
  output logic [63:0]      state_out_1_o,
  output logic [63:0]      state_out_2_o,
  output logic [63:0]      state_out_3_o
);
  import slscp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  slscp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  slscp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .state_in_0_i  (state_in_0_i),
    .state_in_1_i  (state_in_1_i),
    .state_in_2_i  (state_in_2_i),
    .state_in_3_i  (state_in_3_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .state_out_0_o (state_out_0_o),
    .state_out_1_o (state_out_1_o),
    .state_out_2_o (state_out_2_o),
    .state_out_3_o (state_out_3_o)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sLiSCP-light-256 permutation testbench
// Sends 256-bit states through the permutation under several step counts,
// including zero, one, the full eighteen and saturating values. The directed
// table comes first, then random states. Every result is compared lane by lane
// with an in-bench model of the permutation, or with the table value for typed
// rows. Both handshake sides idle at random, with stretches of back-to-back traffic.
// ----------------------------------------------------------------------------
module testbench;

  import slscp_pkg::word_t;
  import slscp_pkg::MAX_STEPS;
  import slscp_pkg::STEP_W;

  // Lane 0 is the leftmost 64-bit word of a literal
  typedef logic [0:3][63:0] block_t;
  typedef logic [STEP_W-1:0] rounds_t;

  typedef struct packed {
    rounds_t rounds;
    logic    typed;
    block_t  data;
    block_t  want;
  } dir_row_t;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = MAX_STEPS + 4;
  localparam int TAIL_CYCLES  = 2 * MAX_STEPS + 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 78;
  localparam int DIR_ROWS     = 20;

  // Per step: round bits box A, round bits box B, step constant A, step constant B
  localparam logic [31:0] STEP_KEYS [MAX_STEPS] = '{
    32'h0f47_0864, 32'h04b2_866b, 32'h43b5_e26f, 32'hf137_892c,
    32'h4496_e6dd, 32'h73ee_ca99, 32'he54c_17ea, 32'h0bf5_8e0f,
    32'h4707_6404, 32'hb282_6b43, 32'hb5a1_6ff1, 32'h3778_2c44,
    32'h96a2_dd73, 32'heeb9_99e5, 32'h4cf2_ea0b, 32'hf585_0f47,
    32'h0723_04b2, 32'h82d9_43b5
  };

  localparam block_t BLK_ZERO  = '0;
  localparam block_t BLK_ONES  = '1;
  localparam block_t BLK_MSB   = {64'h8000_0000_0000_0000, 192'h0};
  localparam block_t BLK_LSB   = {192'h0, 64'h1};
  localparam block_t BLK_AA    = {4{64'hAAAA_AAAA_AAAA_AAAA}};
  localparam block_t BLK_55    = {4{64'h5555_5555_5555_5555}};
  localparam block_t BLK_BYTES = {64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
                                  64'h1011_1213_1415_1617, 64'h1819_1a1b_1c1d_1e1f};
  localparam block_t BLK_MIX   = {64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                                  64'hdead_beef_cafe_f00d, 64'h0f1e_2d3c_4b5a_6978};

  // Zero-step rows carry the input as the expected result
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{5'd18, 1'b0, BLK_ZERO,  BLK_ZERO},
    '{5'd18, 1'b0, BLK_ONES,  BLK_ZERO},
    '{5'd18, 1'b0, BLK_MSB,   BLK_ZERO},
    '{5'd18, 1'b0, BLK_LSB,   BLK_ZERO},
    '{5'd18, 1'b0, BLK_AA,    BLK_ZERO},
    '{5'd18, 1'b0, BLK_55,    BLK_ZERO},
    '{5'd18, 1'b0, BLK_BYTES, BLK_ZERO},
    '{5'd0,  1'b1, BLK_ONES,  BLK_ONES},
    '{5'd0,  1'b1, BLK_MIX,   BLK_MIX},
    '{5'd0,  1'b1, BLK_ZERO,  BLK_ZERO},
    '{5'd1,  1'b0, BLK_ZERO,  BLK_ZERO},
    '{5'd1,  1'b0, BLK_ONES,  BLK_ZERO},
    '{5'd1,  1'b0, BLK_BYTES, BLK_ZERO},
    '{5'd2,  1'b0, BLK_MIX,   BLK_ZERO},
    '{5'd17, 1'b0, BLK_ZERO,  BLK_ZERO},
    '{5'd19, 1'b0, BLK_ZERO,  BLK_ZERO},
    '{5'd19, 1'b0, BLK_BYTES, BLK_ZERO},
    '{5'd31, 1'b0, BLK_ZERO,  BLK_ZERO},
    '{5'd31, 1'b0, BLK_ONES,  BLK_ZERO},
    '{5'd18, 1'b0, BLK_MIX,   BLK_ZERO}
  };

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    cfg_we_i;
  rounds_t cfg_wdata_i;
  logic    in_valid_i;
  logic    in_stall_o;
  block_t  in_blk;
  logic    out_valid_o;
  logic    out_stall_i;
  logic [63:0] out_0, out_1, out_2, out_3;

  block_t  expected_q [$];
  rounds_t cur_rounds;
  logic    no_idle;
  int      mismatch_cnt = 0;
  int      cycle_cnt = 0;

  sliscp_light256_permutation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .state_in_0_i  (in_blk[0]),
    .state_in_1_i  (in_blk[1]),
    .state_in_2_i  (in_blk[2]),
    .state_in_3_i  (in_blk[3]),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .state_out_0_o (out_0),
    .state_out_1_o (out_1),
    .state_out_2_o (out_2),
    .state_out_3_o (out_3)
  );

  // Generate the clock
  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sliscp_light256_permutation verification failed");
      $finish;
    end
  end

  function automatic word_t rotl32(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t simeck_round(input word_t x, input logic rc_bit);
    return (rotl32(x, 5) & x) ^ rotl32(x, 1) ^ 32'hFFFF_FFFE ^ {31'd0, rc_bit};
  endfunction

  // Eight Simeck rounds, round bits taken from the LSB up; returns {a, b}
  function automatic logic [63:0] simeck_pair8(input word_t a_in, input word_t b_in,
                                               input logic [7:0] rc);
    word_t a;
    word_t b;
    a = a_in;
    b = b_in;
    for (int r = 0; r < 4; r++) begin
      b = b ^ simeck_round(a, rc[2*r]);
      a = a ^ simeck_round(b, rc[2*r+1]);
    end
    return {a, b};
  endfunction

  // Expected permuted state for a given step count
  function automatic block_t sliscp_permute(input block_t blk, input rounds_t rounds);
    logic [0:7][31:0] w;
    logic [31:0]      key;
    word_t            t0;
    word_t            t1;
    int               steps;
    block_t           res;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = blk[i][63:32];
      w[2*i+1] = blk[i][31:0];
    end
    steps = (rounds > MAX_STEPS) ? MAX_STEPS : int'(rounds);
    for (int s = 0; s < steps; s++) begin
      key = STEP_KEYS[s];
      {w[2], w[3]} = simeck_pair8(w[2], w[3], key[31:24]);
      {w[6], w[7]} = simeck_pair8(w[6], w[7], key[23:16]);
      w[0] = w[0] ^ 32'hFFFF_FFFF;
      w[1] = w[1] ^ 32'hFFFF_FF00 ^ {24'h0, key[15:8]};
      w[4] = w[4] ^ 32'hFFFF_FFFF;
      w[5] = w[5] ^ 32'hFFFF_FF00 ^ {24'h0, key[7:0]};
      t0 = w[0] ^ w[2];
      t1 = w[1] ^ w[3];
      w[0] = w[2];
      w[1] = w[3];
      w[2] = w[4] ^ w[6];
      w[3] = w[5] ^ w[7];
      w[4] = w[6];
      w[5] = w[7];
      w[6] = t0;
      w[7] = t1;
    end
    for (int i = 0; i < 4; i++) res[i] = {w[2*i], w[2*i+1]};
    return res;
  endfunction

  // Random state, with an occasional all-zero or all-one lane
  function automatic block_t random_block();
    block_t blk;
    int unsigned sel;
    for (int i = 0; i < 4; i++) begin
      sel = $urandom_range(0, 15);
      if (sel == 0) blk[i] = '0;
      else if (sel == 1) blk[i] = '1;
      else blk[i] = {$urandom, $urandom};
    end
    return blk;
  endfunction

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Offer one item, hold it until taken, then queue its expected result
  task automatic send_block(input block_t blk, input logic typed, input block_t want);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_blk     <= blk;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(typed ? want : sliscp_permute(blk, cur_rounds));
  endtask

  // Drain the block, then write the step count
  task automatic set_round_count(input rounds_t value);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_rounds = value;
  endtask

  // Take results with random stalls and compare them
  initial begin : result_sink
    int unsigned hold;
    block_t got;
    block_t want;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = {out_0, out_1, out_2, out_3};
      if (expected_q.size() == 0) begin
        note_error($sformatf("unexpected result %h", got));
      end else begin
        want = expected_q.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[k] !== want[k])
            note_error($sformatf("state_out_%0d: got %h, want %h", k, got[k], want[k]));
        end
      end
    end
  end

  // Reset, directed table, random phases, then drain and report
  initial begin
    rounds_t phase_rounds;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    in_blk       = '0;
    no_idle      = 1'b0;
    cur_rounds   = rounds_t'(MAX_STEPS);
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].rounds != cur_rounds) set_round_count(DIR_TABLE[r].rounds);
      send_block(DIR_TABLE[r].data, DIR_TABLE[r].typed, DIR_TABLE[r].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       phase_rounds = 5'd0;
        1:       phase_rounds = 5'd31;
        2:       phase_rounds = 5'd1;
        3:       phase_rounds = rounds_t'(MAX_STEPS);
        default: phase_rounds = rounds_t'($urandom_range(0, 31));
      endcase
      set_round_count(phase_rounds);
      no_idle = (p % 4 == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) send_block(random_block(), 1'b0, BLK_ZERO);
    end

    in_valid_i <= 1'b0;
    no_idle = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("sliscp_light256_permutation verification clean");
    end else begin
      $display("sliscp_light256_permutation verification failed");
    end
    $finish;
  end

endmodule
